[rtl/lrq_pkg.sv]
// ----------------------------------------------------------------------------
// lrq_pkg
// Shared types and constants of the LRU/LFU replacement queue.
// ----------------------------------------------------------------------------
package lrq_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int KEY_BITS_DEF   = 32;
    localparam int COUNT_BITS_DEF = 16;

    // payload port widths
    localparam int KIND_W   = 2;
    localparam int KEY_W    = 32;
    localparam int COUNT_W  = 16;
    localparam int STATUS_W = 2;

    // register file
    localparam int             CFG_ADDR_W      = 3;
    localparam int             CFG_DATA_W      = 32;
    localparam logic           CFG_IDX_POLICY  = 1'b0;

    typedef enum logic [1:0] {
        KIND_TOUCH  = 2'd0,
        KIND_EVICT  = 2'd1,
        KIND_REMOVE = 2'd2,
        KIND_NOP    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_MISS  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        LOP_HOLD,
        LOP_ROT,
        LOP_DROP,
        LOP_INS
    } list_op_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_FIND,
        SEQ_PLACE,
        SEQ_FINISH
    } seq_state_t;

endpackage

[rtl/lrq_list.sv]
// ----------------------------------------------------------------------------
// lrq_list
// Ordered entry store: a recirculating shift line whose head is the victim.
// ----------------------------------------------------------------------------
module lrq_list #(
    parameter int DEPTH      = lrq_pkg::DEPTH_DEF,
    parameter int KEY_BITS   = lrq_pkg::KEY_BITS_DEF,
    parameter int COUNT_BITS = lrq_pkg::COUNT_BITS_DEF,
    localparam int OCC_W     = $clog2(DEPTH + 1)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  lrq_pkg::list_op_t     op,
    input  logic [KEY_BITS-1:0]   ins_key,
    input  logic [COUNT_BITS-1:0] ins_count,
    output logic [KEY_BITS-1:0]   head_key,
    output logic [COUNT_BITS-1:0] head_count,
    output logic [OCC_W-1:0]      len
);

    localparam int IDX_W = $clog2(DEPTH);

    logic [KEY_BITS-1:0]   key_reg   [DEPTH];
    logic [COUNT_BITS-1:0] count_reg [DEPTH];
    logic [KEY_BITS-1:0]   up_key    [DEPTH];
    logic [COUNT_BITS-1:0] up_count  [DEPTH];
    logic [OCC_W-1:0]      len_reg, len_next;
    logic [IDX_W-1:0]      tail_idx, ins_idx;

    // each slot takes from its upper neighbour when the line moves
    for (genvar g = 0; g < DEPTH; g++) begin : g_up
        if (g < DEPTH - 1) begin : g_mid
            assign up_key[g]   = key_reg[g+1];
            assign up_count[g] = count_reg[g+1];
        end else begin : g_top
            assign up_key[g]   = key_reg[g];
            assign up_count[g] = count_reg[g];
        end
    end

    assign tail_idx = IDX_W'(len_reg - OCC_W'(1));
    assign ins_idx  = IDX_W'(len_reg);

    always_ff @(posedge aclk) begin
        for (int i = 0; i < DEPTH; i++) begin
            case (op)
                lrq_pkg::LOP_ROT: begin
                    if (IDX_W'(i) == tail_idx) begin
                        key_reg[i]   <= key_reg[0];
                        count_reg[i] <= count_reg[0];
                    end else begin
                        key_reg[i]   <= up_key[i];
                        count_reg[i] <= up_count[i];
                    end
                end
                lrq_pkg::LOP_DROP: begin
                    key_reg[i]   <= up_key[i];
                    count_reg[i] <= up_count[i];
                end
                lrq_pkg::LOP_INS: begin
                    if (IDX_W'(i) == ins_idx) begin
                        key_reg[i]   <= ins_key;
                        count_reg[i] <= ins_count;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (op)
            lrq_pkg::LOP_DROP: len_next = len_reg - OCC_W'(1);
            lrq_pkg::LOP_INS:  len_next = len_reg + OCC_W'(1);
            default:           len_next = len_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= '0;
        end else begin
            len_reg <= len_next;
        end
    end

    assign head_key   = key_reg[0];
    assign head_count = count_reg[0];
    assign len        = len_reg;

endmodule

[rtl/lru_lfu_replacement_queue.sv]
// ----------------------------------------------------------------------------
// lru_lfu_replacement_queue
// Replacement list with LRU or LFU ordering, evict head and remove by key.
// ----------------------------------------------------------------------------
// The list lives in a recirculating shift line; one key compare and one count
// compare at its head do all the searching, one entry per cycle. An evict or
// unused kind goes from acceptance straight to its result; a remove or an LRU
// touch makes a find pass over the n valid entries, and an LFU touch makes
// a find pass over n entries, then a placement pass over what is left. The
// input is taken only while no item is in progress; a finished result waits
// in the output register while the next item is accepted. The list is empty
// after reset and needs no clearing pass.
module lru_lfu_replacement_queue #(
    parameter int DEPTH      = lrq_pkg::DEPTH_DEF,
    parameter int KEY_BITS   = lrq_pkg::KEY_BITS_DEF,
    parameter int COUNT_BITS = lrq_pkg::COUNT_BITS_DEF,
    localparam int OCC_W     = $clog2(DEPTH + 1)
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input items
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [lrq_pkg::KIND_W-1:0]        s_kind,
    input  logic [lrq_pkg::KEY_W-1:0]         s_key,
    input  logic [lrq_pkg::COUNT_W-1:0]       s_initial_count,
    // result items
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [lrq_pkg::STATUS_W-1:0]      m_status,
    output logic                              m_hit,
    output logic [lrq_pkg::KEY_W-1:0]         m_victim_key,
    output logic [lrq_pkg::COUNT_W-1:0]       m_entry_count,
    output logic [OCC_W-1:0]                  m_occupancy,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lrq_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [lrq_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [lrq_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                              pready
);

    localparam logic [31:0] CMAX = 32'((64'd1 << COUNT_BITS) - 64'd1);

    lrq_pkg::seq_state_t state_reg, state_next;
    lrq_pkg::list_op_t   list_op;

    lrq_pkg::kind_t        kind_reg, kind_next;
    lrq_pkg::status_t      status_reg, status_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [KEY_BITS-1:0]   victim_reg, victim_next;
    logic [OCC_W-1:0]      steps_reg, steps_next;
    logic                  found_reg, found_next;
    logic                  inserted_reg, inserted_next;
    logic                  hit_reg, hit_next;
    logic                  policy_mode_reg;

    logic                  m_valid_reg, m_valid_next;
    logic [1:0]            m_status_reg;
    logic                  m_hit_reg;
    logic [KEY_BITS-1:0]   m_victim_reg;
    logic [COUNT_BITS-1:0] m_count_reg;
    logic [OCC_W-1:0]      m_occ_reg;

    logic [KEY_BITS-1:0]   head_key;
    logic [COUNT_BITS-1:0] head_count;
    logic [OCC_W-1:0]      len;
    logic [KEY_BITS-1:0]   key_in;
    logic [31:0]           init_ext;
    logic [COUNT_BITS-1:0] init_sat;
    logic [COUNT_BITS-1:0] head_inc;
    logic                  head_match;
    logic                  count_less;
    logic                  scan_done;
    logic                  full;
    logic                  accept;
    logic                  load_out;
    logic                  cfg_write;

    lrq_list #(
        .DEPTH      (DEPTH),
        .KEY_BITS   (KEY_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_list (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .op         (list_op),
        .ins_key    (key_reg),
        .ins_count  (count_reg),
        .head_key   (head_key),
        .head_count (head_count),
        .len        (len)
    );

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite
                    && (paddr[lrq_pkg::CFG_ADDR_W-1:2] == lrq_pkg::CFG_IDX_POLICY);
    assign prdata    = (paddr[lrq_pkg::CFG_ADDR_W-1:2] == lrq_pkg::CFG_IDX_POLICY)
                     ? lrq_pkg::CFG_DATA_W'(policy_mode_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            policy_mode_reg <= 1'b0;
        end else if (cfg_write) begin
            policy_mode_reg <= pwdata[0];
        end
    end

    // ------------------------------------------------------------------
    // shared compare unit at the list head
    // ------------------------------------------------------------------
    assign key_in     = KEY_BITS'(s_key);
    assign init_ext   = 32'(s_initial_count);
    assign init_sat   = COUNT_BITS'((init_ext > CMAX) ? CMAX : init_ext);
    assign head_inc   = (head_count == {COUNT_BITS{1'b1}})
                      ? head_count : head_count + COUNT_BITS'(1);
    assign head_match = (head_key == key_reg);
    assign count_less = (count_reg < head_count);
    assign scan_done  = (steps_reg == '0);
    assign full       = (len == OCC_W'(DEPTH));
    assign accept     = s_valid && s_ready;
    assign load_out   = (state_reg == lrq_pkg::SEQ_FINISH) && (!m_valid_reg || m_ready);

    // ------------------------------------------------------------------
    // sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lrq_pkg::SEQ_IDLE: begin
                if (accept) begin
                    if (lrq_pkg::kind_t'(s_kind) == lrq_pkg::KIND_TOUCH
                        || lrq_pkg::kind_t'(s_kind) == lrq_pkg::KIND_REMOVE) begin
                        state_next = lrq_pkg::SEQ_FIND;
                    end else begin
                        state_next = lrq_pkg::SEQ_FINISH;
                    end
                end
            end
            lrq_pkg::SEQ_FIND: begin
                if (scan_done) begin
                    if (kind_reg == lrq_pkg::KIND_TOUCH && (found_reg || !full)
                        && policy_mode_reg) begin
                        state_next = lrq_pkg::SEQ_PLACE;
                    end else begin
                        state_next = lrq_pkg::SEQ_FINISH;
                    end
                end
            end
            lrq_pkg::SEQ_PLACE: begin
                if (scan_done) begin
                    state_next = lrq_pkg::SEQ_FINISH;
                end
            end
            lrq_pkg::SEQ_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = lrq_pkg::SEQ_IDLE;
                end
            end
            default: state_next = lrq_pkg::SEQ_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // sequencer: list commands and working registers
    // ------------------------------------------------------------------
    always_comb begin
        list_op       = lrq_pkg::LOP_HOLD;
        kind_next     = kind_reg;
        status_next   = status_reg;
        key_next      = key_reg;
        count_next    = count_reg;
        victim_next   = victim_reg;
        steps_next    = steps_reg;
        found_next    = found_reg;
        inserted_next = inserted_reg;
        hit_next      = hit_reg;
        case (state_reg)
            lrq_pkg::SEQ_IDLE: begin
                if (accept) begin
                    kind_next     = lrq_pkg::kind_t'(s_kind);
                    key_next      = key_in;
                    count_next    = (lrq_pkg::kind_t'(s_kind) == lrq_pkg::KIND_TOUCH)
                                  ? init_sat : '0;
                    steps_next    = len;
                    found_next    = 1'b0;
                    inserted_next = 1'b0;
                    status_next   = lrq_pkg::STAT_OK;
                    hit_next      = 1'b0;
                    victim_next   = '0;
                    if (lrq_pkg::kind_t'(s_kind) == lrq_pkg::KIND_EVICT) begin
                        if (len == '0) begin
                            status_next = lrq_pkg::STAT_EMPTY;
                        end else begin
                            hit_next    = 1'b1;
                            victim_next = head_key;
                            count_next  = head_count;
                            list_op     = lrq_pkg::LOP_DROP;
                        end
                    end
                end
            end
            lrq_pkg::SEQ_FIND: begin
                if (!scan_done) begin
                    steps_next = steps_reg - OCC_W'(1);
                    if (head_match && !found_reg) begin
                        // take the entry out; the rest of the line closes up
                        list_op    = lrq_pkg::LOP_DROP;
                        found_next = 1'b1;
                        hit_next   = 1'b1;
                        count_next = (policy_mode_reg && kind_reg == lrq_pkg::KIND_TOUCH)
                                   ? head_inc : head_count;
                    end else begin
                        list_op = lrq_pkg::LOP_ROT;
                    end
                end else if (kind_reg == lrq_pkg::KIND_REMOVE) begin
                    if (!found_reg) begin
                        status_next = lrq_pkg::STAT_MISS;
                    end
                end else if (kind_reg == lrq_pkg::KIND_TOUCH) begin
                    if (!found_reg && full) begin
                        status_next = lrq_pkg::STAT_FULL;
                    end else if (!policy_mode_reg) begin
                        list_op = lrq_pkg::LOP_INS;
                    end else begin
                        steps_next = len;
                    end
                end
            end
            lrq_pkg::SEQ_PLACE: begin
                if (scan_done) begin
                    if (!inserted_reg) begin
                        list_op = lrq_pkg::LOP_INS;
                    end
                end else if (!inserted_reg && count_less) begin
                    // new entry goes in ahead of the first larger count
                    list_op       = lrq_pkg::LOP_INS;
                    inserted_next = 1'b1;
                end else begin
                    list_op    = lrq_pkg::LOP_ROT;
                    steps_next = steps_reg - OCC_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lrq_pkg::SEQ_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg     <= kind_next;
        status_reg   <= status_next;
        key_reg      <= key_next;
        count_reg    <= count_next;
        victim_reg   <= victim_next;
        steps_reg    <= steps_next;
        found_reg    <= found_next;
        inserted_reg <= inserted_next;
        hit_reg      <= hit_next;
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    assign m_valid_next = load_out ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_status_reg <= status_reg;
            m_hit_reg    <= hit_reg;
            m_victim_reg <= victim_reg;
            m_count_reg  <= (status_reg == lrq_pkg::STAT_OK) ? count_reg : '0;
            m_occ_reg    <= len;
        end
    end

    assign s_ready       = (state_reg == lrq_pkg::SEQ_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_hit         = m_hit_reg;
    assign m_victim_key  = lrq_pkg::KEY_W'(m_victim_reg);
    assign m_entry_count = lrq_pkg::COUNT_W'(m_count_reg);
    assign m_occupancy   = m_occ_reg;

endmodule

[rtl/lrq_checker.sv]
// ----------------------------------------------------------------------------
// lrq_checker
// Port-level checks of the replacement queue, bound to the top level.
// ----------------------------------------------------------------------------
module lrq_checker #(
    parameter int DEPTH  = lrq_pkg::DEPTH_DEF,
    localparam int OCC_W = $clog2(DEPTH + 1)
) (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [lrq_pkg::STATUS_W-1:0] m_status,
    input logic                         m_hit,
    input logic [lrq_pkg::KEY_W-1:0]    m_victim_key,
    input logic [lrq_pkg::COUNT_W-1:0]  m_entry_count,
    input logic [OCC_W-1:0]             m_occupancy
);

    // one item at a time: the block is busy right after taking an item
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while an item is in progress");

    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_occupancy <= OCC_W'(DEPTH)))
        else $error("occupancy above list depth");

    a_empty_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == lrq_pkg::STAT_EMPTY) |->
            (m_occupancy == '0 && !m_hit && m_entry_count == '0))
        else $error("empty evict with non-empty result");

    a_victim_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_victim_key != '0) |-> (m_hit && m_status == lrq_pkg::STAT_OK))
        else $error("victim key without a hit");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_status) && $stable(m_victim_key)
            && $stable(m_occupancy)))
        else $error("stalled result changed");

endmodule

bind lru_lfu_replacement_queue lrq_checker #(
    .DEPTH (DEPTH)
) u_lrq_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_status      (m_status),
    .m_hit         (m_hit),
    .m_victim_key  (m_victim_key),
    .m_entry_count (m_entry_count),
    .m_occupancy   (m_occupancy)
);

[tb/lru_lfu_replacement_queue_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lru_lfu_replacement_queue_test
// Self-checking bench for the replacement queue. A list model in the bench
// tracks keys, counts and order under both policies and predicts every
// result. Directed items cover the corner cases, then random traffic runs in
// fill, drain and mixed phases with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module lru_lfu_replacement_queue_test;

    localparam int LIST_DEPTH    = lrq_pkg::DEPTH_DEF;
    localparam int IDLE_LIMIT    = 3000;
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_ITEMS  = 2000;
    localparam int PHASE_ITEMS   = 100;
    localparam int POOL_SIZE     = 24;
    localparam logic [lrq_pkg::CFG_ADDR_W-1:0] ADDR_POLICY = {lrq_pkg::CFG_IDX_POLICY, 2'b00};
    localparam logic [lrq_pkg::CFG_ADDR_W-1:0] ADDR_UNUSED = 3'd4;
    localparam logic [lrq_pkg::COUNT_W-1:0]    COUNT_MAX   = '1;

    typedef struct {
        lrq_pkg::status_t             status;
        logic                         hit;
        logic [lrq_pkg::KEY_W-1:0]    victim;
        logic [lrq_pkg::COUNT_W-1:0]  count;
        logic [4:0]                   occupancy;
    } outcome_t;

    logic                                 aclk;
    logic                                 aresetn;
    logic                                 s_valid;
    logic                                 s_ready;
    logic [lrq_pkg::KIND_W-1:0]           s_kind;
    logic [lrq_pkg::KEY_W-1:0]            s_key;
    logic [lrq_pkg::COUNT_W-1:0]          s_initial_count;
    logic                                 m_valid;
    logic                                 m_ready;
    logic [lrq_pkg::STATUS_W-1:0]         m_status;
    logic                                 m_hit;
    logic [lrq_pkg::KEY_W-1:0]            m_victim_key;
    logic [lrq_pkg::COUNT_W-1:0]          m_entry_count;
    logic [4:0]                           m_occupancy;
    logic                                 psel;
    logic                                 penable;
    logic                                 pwrite;
    logic [lrq_pkg::CFG_ADDR_W-1:0]       paddr;
    logic [lrq_pkg::CFG_DATA_W-1:0]       pwdata;
    logic [lrq_pkg::CFG_DATA_W-1:0]       prdata;
    logic                                 pready;

    // list model: entry 0 is the head
    logic [lrq_pkg::KEY_W-1:0]            held_key [LIST_DEPTH];
    logic [lrq_pkg::COUNT_W-1:0]          held_count [LIST_DEPTH];
    int                                   held_len;
    logic                                 lfu_mode;

    outcome_t                             pending_outcomes [$];
    logic [lrq_pkg::KEY_W-1:0]            key_pool [POOL_SIZE];
    logic                                 steady_flow;
    int unsigned                          hold_left;
    int                                   idle_cycles;
    int                                   errors;
    int                                   items_sent;
    int                                   results_checked;
    int                                   hits_seen;
    int                                   full_rejects;
    int                                   empty_evicts;
    int                                   policy_writes;

    lru_lfu_replacement_queue dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_key           (s_key),
        .s_initial_count (s_initial_count),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_hit           (m_hit),
        .m_victim_key    (m_victim_key),
        .m_entry_count   (m_entry_count),
        .m_occupancy     (m_occupancy),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int locate_key(logic [lrq_pkg::KEY_W-1:0] key);
        for (int i = 0; i < held_len; i++)
            if (held_key[i] == key)
                return i;
        return -1;
    endfunction

    function automatic void take_out(int pos);
        for (int i = pos; i + 1 < held_len; i++) begin
            held_key[i]   = held_key[i + 1];
            held_count[i] = held_count[i + 1];
        end
        held_len--;
    endfunction

    function automatic void put_in(int pos, logic [lrq_pkg::KEY_W-1:0] key,
                                   logic [lrq_pkg::COUNT_W-1:0] cnt);
        for (int i = held_len; i > pos; i--) begin
            held_key[i]   = held_key[i - 1];
            held_count[i] = held_count[i - 1];
        end
        held_key[pos]   = key;
        held_count[pos] = cnt;
        held_len++;
    endfunction

    // after every entry whose count is not greater, so ties keep recency order
    function automatic int count_slot(logic [lrq_pkg::COUNT_W-1:0] cnt);
        for (int i = 0; i < held_len; i++)
            if (cnt < held_count[i])
                return i;
        return held_len;
    endfunction

    function automatic outcome_t apply_item(lrq_pkg::kind_t kind,
                                            logic [lrq_pkg::KEY_W-1:0] key,
                                            logic [lrq_pkg::COUNT_W-1:0] init);
        outcome_t                    res;
        int                          pos;
        logic [lrq_pkg::COUNT_W-1:0] cnt;
        res.status = lrq_pkg::STAT_OK;
        res.hit    = 1'b0;
        res.victim = '0;
        res.count  = '0;
        case (kind)
            lrq_pkg::KIND_TOUCH: begin
                pos = locate_key(key);
                if (pos >= 0) begin
                    cnt = held_count[pos];
                    if (lfu_mode && cnt != COUNT_MAX)
                        cnt++;
                    take_out(pos);
                    put_in(lfu_mode ? count_slot(cnt) : held_len, key, cnt);
                    res.hit   = 1'b1;
                    res.count = cnt;
                end else if (held_len >= LIST_DEPTH) begin
                    res.status = lrq_pkg::STAT_FULL;
                end else begin
                    put_in(lfu_mode ? count_slot(init) : held_len, key, init);
                    res.count = init;
                end
            end
            lrq_pkg::KIND_EVICT: begin
                if (held_len == 0) begin
                    res.status = lrq_pkg::STAT_EMPTY;
                end else begin
                    res.hit    = 1'b1;
                    res.victim = held_key[0];
                    res.count  = held_count[0];
                    take_out(0);
                end
            end
            lrq_pkg::KIND_REMOVE: begin
                pos = locate_key(key);
                if (pos < 0) begin
                    res.status = lrq_pkg::STAT_MISS;
                end else begin
                    res.hit   = 1'b1;
                    res.count = held_count[pos];
                    take_out(pos);
                end
            end
            default: ;
        endcase
        res.occupancy = 5'(held_len);
        return res;
    endfunction

    function automatic int unsigned draw_wait();
        return steady_flow ? 0 : $urandom_range(0, 16);
    endfunction

    function automatic logic [lrq_pkg::KEY_W-1:0] pick_key(int span);
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        return key_pool[$urandom_range(0, span - 1)];
    endfunction

    // small counts most of the time so that ties are common
    function automatic logic [lrq_pkg::COUNT_W-1:0] pick_count();
        case ($urandom_range(0, 9))
            6, 7:    return lrq_pkg::COUNT_W'($urandom);
            8:       return COUNT_MAX;
            9:       return COUNT_MAX - 1'b1;
            default: return lrq_pkg::COUNT_W'($urandom_range(0, 3));
        endcase
    endfunction

    function automatic void flag_mismatch(string field, longint want, longint got);
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
        errors++;
    endfunction

    function automatic void check_outcome();
        outcome_t want;
        if (pending_outcomes.size() == 0) begin
            $display("%0t: result with no item outstanding, status %0d occupancy %0d",
                     $time, m_status, m_occupancy);
            errors++;
            return;
        end
        want = pending_outcomes.pop_front();
        results_checked++;
        if (m_status !== want.status)
            flag_mismatch("status", want.status, m_status);
        if (m_hit !== want.hit)
            flag_mismatch("hit", want.hit, m_hit);
        if (m_victim_key !== want.victim)
            flag_mismatch("victim_key", want.victim, m_victim_key);
        if (m_entry_count !== want.count)
            flag_mismatch("entry_count", want.count, m_entry_count);
        if (m_occupancy !== want.occupancy)
            flag_mismatch("occupancy", want.occupancy, m_occupancy);
    endfunction

    // result side: check, then stall for a drawn number of cycles
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            hold_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                check_outcome();
                hold_left = draw_wait();
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic send_item(lrq_pkg::kind_t kind, logic [lrq_pkg::KEY_W-1:0] key,
                             logic [lrq_pkg::COUNT_W-1:0] init);
        int unsigned gap;
        outcome_t    res;
        gap = draw_wait();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_kind          <= kind;
        s_key           <= key;
        s_initial_count <= init;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        res = apply_item(kind, key, init);
        pending_outcomes.push_back(res);
        items_sent++;
        if (res.hit)
            hits_seen++;
        if (res.status == lrq_pkg::STAT_FULL)
            full_rejects++;
        if (res.status == lrq_pkg::STAT_EMPTY)
            empty_evicts++;
    endtask

    task automatic drain_results(int settle);
        s_valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic write_reg(logic [lrq_pkg::CFG_ADDR_W-1:0] addr,
                             logic [lrq_pkg::CFG_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        if (addr == ADDR_POLICY)
            lfu_mode = data[0];
        policy_writes++;
    endtask

    task automatic check_policy_readback();
        logic [lrq_pkg::CFG_DATA_W-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_POLICY;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        if (got !== lrq_pkg::CFG_DATA_W'(lfu_mode)) begin
            $display("%0t: policy_mode readback, expected %0h, got %0h",
                     $time, lfu_mode, got);
            errors++;
        end
    endtask

    // upper data bits are random and must be ignored
    task automatic set_policy(logic mode);
        drain_results(4);
        write_reg(ADDR_POLICY, {31'($urandom), mode});
        check_policy_readback();
    endtask

    task automatic test_register_access();
        write_reg(ADDR_POLICY, 32'hffff_ffff);
        check_policy_readback();
        write_reg(ADDR_UNUSED, 32'h0000_0000);
        check_policy_readback();
        write_reg(ADDR_POLICY, 32'hffff_fffe);
        check_policy_readback();
    endtask

    task automatic test_empty_list();
        send_item(lrq_pkg::KIND_EVICT, 32'hffff_ffff, COUNT_MAX);
        send_item(lrq_pkg::KIND_REMOVE, 32'h1234_5678, 16'h0000);
        send_item(lrq_pkg::KIND_NOP, 32'hffff_ffff, COUNT_MAX);
    endtask

    task automatic test_lru_order();
        set_policy(1'b0);
        send_item(lrq_pkg::KIND_TOUCH, 32'h0000_0000, 16'h0000);
        send_item(lrq_pkg::KIND_TOUCH, 32'hffff_ffff, COUNT_MAX);
        // hit keeps its count, only moves to the tail
        send_item(lrq_pkg::KIND_TOUCH, 32'h0000_0000, 16'h0007);
        send_item(lrq_pkg::KIND_EVICT, 32'h0000_0000, 16'h0000);
        send_item(lrq_pkg::KIND_REMOVE, 32'h0000_0000, 16'h0000);
    endtask

    task automatic test_lfu_order();
        set_policy(1'b1);
        send_item(lrq_pkg::KIND_TOUCH, 32'h0000_00a1, 16'd5);
        send_item(lrq_pkg::KIND_TOUCH, 32'h0000_00b2, 16'd5);
        send_item(lrq_pkg::KIND_TOUCH, 32'h0000_00c3, 16'd2);
        send_item(lrq_pkg::KIND_TOUCH, 32'h0000_00a1, 16'd0);
        send_item(lrq_pkg::KIND_TOUCH, 32'h0000_00d4, COUNT_MAX);
        // count already at its maximum, must not wrap
        send_item(lrq_pkg::KIND_TOUCH, 32'h0000_00d4, 16'd0);
        send_item(lrq_pkg::KIND_TOUCH, 32'h0000_00b2, 16'd0);
        send_item(lrq_pkg::KIND_EVICT, 32'h0000_0000, 16'd0);
    endtask

    // switch policy with entries present, then fill to the limit
    task automatic test_full_list();
        set_policy(1'b0);
        while (held_len < LIST_DEPTH)
            send_item(lrq_pkg::KIND_TOUCH, $urandom,
                      lrq_pkg::COUNT_W'($urandom_range(0, 7)));
        send_item(lrq_pkg::KIND_TOUCH, 32'h5555_aaaa, 16'd1);
        send_item(lrq_pkg::KIND_TOUCH, 32'h0000_00a1, 16'd1);
    endtask

    task automatic test_random_traffic();
        int             done;
        int             span;
        int             weight_touch;
        int             weight_evict;
        int             roll;
        lrq_pkg::kind_t kind;
        done = 0;
        while (done < RANDOM_ITEMS) begin
            set_policy(1'($urandom_range(0, 1)));
            steady_flow = ($urandom_range(0, 3) == 0);
            span = $urandom_range(4, POOL_SIZE);
            case ($urandom_range(0, 2))
                0: begin
                    weight_touch = 80;
                    weight_evict = 5;
                end
                1: begin
                    weight_touch = 30;
                    weight_evict = 40;
                end
                default: begin
                    weight_touch = 55;
                    weight_evict = 15;
                end
            endcase
            repeat (PHASE_ITEMS) begin
                roll = $urandom_range(0, 99);
                if (roll < weight_touch)
                    kind = lrq_pkg::KIND_TOUCH;
                else if (roll < weight_touch + weight_evict)
                    kind = lrq_pkg::KIND_EVICT;
                else if (roll < 95)
                    kind = lrq_pkg::KIND_REMOVE;
                else
                    kind = lrq_pkg::KIND_NOP;
                send_item(kind, pick_key(span), pick_count());
                if (kind != lrq_pkg::KIND_NOP)
                    done++;
            end
        end
        steady_flow = 1'b0;
    endtask

    initial begin
        aclk            = 1'b0;
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_kind          = lrq_pkg::KIND_TOUCH;
        s_key           = '0;
        s_initial_count = '0;
        m_ready         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        held_len        = 0;
        lfu_mode        = 1'b0;
        steady_flow     = 1'b0;
        idle_cycles     = 0;
        errors          = 0;
        items_sent      = 0;
        results_checked = 0;
        hits_seen       = 0;
        full_rejects    = 0;
        empty_evicts    = 0;
        policy_writes   = 0;
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hffff_ffff;
        for (int i = 2; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        check_policy_readback();
        test_register_access();
        test_empty_list();
        test_lru_order();
        test_lfu_order();
        test_full_list();
        test_random_traffic();
        drain_results(SETTLE_CYCLES);

        $display("ran %0d items under both policies, %0d results checked, %0d hits",
                 items_sent, results_checked, hits_seen);
        $display("%0d full-list rejections, %0d evicts on an empty list, %0d register writes",
                 full_rejects, empty_evicts, policy_writes);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
